// File: rtl/eci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eci_pkg;

  // curve families and their in / out / in-out forms
  typedef enum logic [2:0] {
    FAM_LINEAR,
    FAM_POLY,
    FAM_SINE,
    FAM_EXPO,
    FAM_CIRC
  } curve_fam_e;

  typedef enum logic [1:0] {
    MODE_IN,
    MODE_OUT,
    MODE_INOUT
  } curve_mode_e;

  typedef struct packed {
    curve_fam_e  fam;
    curve_mode_e mode;
    logic [2:0]  order;
  } curve_t;

  // register map, one word each
  typedef enum logic [1:0] {
    REG_CURVE,
    REG_START,
    REG_END,
    REG_FRAMES
  } reg_e;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;

  // product of two q16 fractions, both at most one
  function automatic logic [16:0] mulq(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b);
    return p[32:16];
  endfunction

  // q30 sum to q16, rounded and limited to one
  function automatic logic [16:0] q30_to_q16(input longint s);
    longint r;
    if (s < 0) begin
      return 17'd0;
    end
    r = (s + 64'sd8192) >>> 14;
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end
    return 17'(r);
  endfunction

  function automatic curve_t mk_curve(input curve_fam_e fam, input curve_mode_e mode,
                                      input logic [2:0] order);
    curve_t c;
    c.fam   = fam;
    c.mode  = mode;
    c.order = order;
    return c;
  endfunction

  // curve code to family, form and polynomial order; spare codes are linear
  function automatic curve_t decode_curve(input logic [4:0] sel);
    curve_t c;
    case (sel)
      5'd1:    c = mk_curve(FAM_POLY, MODE_IN,    3'd2);
      5'd2:    c = mk_curve(FAM_POLY, MODE_OUT,   3'd2);
      5'd3:    c = mk_curve(FAM_POLY, MODE_INOUT, 3'd2);
      5'd4:    c = mk_curve(FAM_POLY, MODE_IN,    3'd3);
      5'd5:    c = mk_curve(FAM_POLY, MODE_OUT,   3'd3);
      5'd6:    c = mk_curve(FAM_POLY, MODE_INOUT, 3'd3);
      5'd7:    c = mk_curve(FAM_POLY, MODE_IN,    3'd4);
      5'd8:    c = mk_curve(FAM_POLY, MODE_OUT,   3'd4);
      5'd9:    c = mk_curve(FAM_POLY, MODE_INOUT, 3'd4);
      5'd10:   c = mk_curve(FAM_POLY, MODE_IN,    3'd5);
      5'd11:   c = mk_curve(FAM_POLY, MODE_OUT,   3'd5);
      5'd12:   c = mk_curve(FAM_POLY, MODE_INOUT, 3'd5);
      5'd13:   c = mk_curve(FAM_SINE, MODE_IN,    3'd2);
      5'd14:   c = mk_curve(FAM_SINE, MODE_OUT,   3'd2);
      5'd15:   c = mk_curve(FAM_SINE, MODE_INOUT, 3'd2);
      5'd16:   c = mk_curve(FAM_EXPO, MODE_IN,    3'd2);
      5'd17:   c = mk_curve(FAM_EXPO, MODE_OUT,   3'd2);
      5'd18:   c = mk_curve(FAM_EXPO, MODE_INOUT, 3'd2);
      5'd19:   c = mk_curve(FAM_CIRC, MODE_IN,    3'd2);
      5'd20:   c = mk_curve(FAM_CIRC, MODE_OUT,   3'd2);
      5'd21:   c = mk_curve(FAM_CIRC, MODE_INOUT, 3'd2);
      default: c = mk_curve(FAM_LINEAR, MODE_IN,  3'd2);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/easing_curve_interpolator_top.sv
// channel   | ports                                        | request taken when
// ----------+----------------------------------------------+-----------------------------
// input     | start, busy, frame_count_i                   | start high, busy low
// result    | done_o, eased_value_o                        | every cycle done_o is high
// config    | psel, penable, pwrite, paddr, pwdata, prdata | psel, penable, pwrite high
//
// one request enters every cycle; busy is never raised
// stages in order: clamp, five divider stages of four quotient bits, argument
// set-up, seven curve stages (set by the seventeen-step square root), select, scale, round
// the receiver cannot stall, so each result shows on done_o for a single cycle
// reset clears the stage valid bits and loads the registers with their reset values
`timescale 1ns / 1ps
`default_nettype none

module easing_curve_interpolator_top #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int EXP_TABLE_DEPTH  = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        frame_count_i,
  output logic                    done_o,
  output logic signed [15:0]      eased_value_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int SIW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int EIW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SPW = 16 + SIW;
  localparam int EPW = 16 + EIW;
  localparam logic [SIW-1:0] SINE_LAST = SIW'(SINE_TABLE_DEPTH);

  typedef logic [16:0] sine_rom_t [SINE_TABLE_DEPTH+1];
  typedef logic [16:0] exp_rom_t  [EXP_TABLE_DEPTH+1];

  // quarter-wave sine, taylor series in q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = eci_pkg::HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int i = 1; i <= 7; i++) begin
        term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
        if ((i % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      rom[k] = eci_pkg::q30_to_q16(sum);
    end
    return rom;
  endfunction

  // 2^-(j/D) as exp(-j ln2 / D), taylor series in q30
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] z;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      z    = eci_pkg::LN2_Q30 * 64'(k) / EXP_TABLE_DEPTH;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int i = 1; i <= 12; i++) begin
        term = ((term * z) >> 30) / 64'(i);
        if ((i % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      rom[k] = eci_pkg::q30_to_q16(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam exp_rom_t  EXP_ROM  = build_exp_rom();

  // configuration registers
  logic [4:0]          curve_q;
  logic signed [15:0]  start_val_q;
  logic signed [15:0]  end_val_q;
  logic [15:0]         frames_q;
  logic                cfg_wr;
  eci_pkg::reg_e       cfg_reg;
  eci_pkg::curve_t     cur;
  logic [15:0]         frames;

  // divider
  logic        dv_q   [6];
  logic [16:0] drem_q [6];
  logic [16:0] dquo_q [6];
  logic [15:0] cnt_clamp;

  // argument set-up
  logic [16:0] t_in;
  logic [16:0] u_in;
  logic [17:0] t2w;
  logic [16:0] t2;
  logic [16:0] u2;
  logic        low_in;
  logic [16:0] xa_d;
  logic [16:0] xb_d;

  // control line and curve units, index is stage after set-up
  logic        pv_q [8];
  logic [16:0] tp_q [8];
  logic [16:0] xa_q [4];
  logic [16:0] xb_q;
  logic [16:0] pw_q [1:7];

  logic [SIW-1:0] sidx_q;
  logic [15:0]    sfr_q;
  logic           ssat_q;
  logic [16:0]    sa_q;
  logic [16:0]    sb_q;
  logic [15:0]    sfr2_q;
  logic [16:0]    sv_q [3:7];
  logic [SPW-1:0] sp_d;

  logic [19:0]    ee_q;
  logic [3:0]     eip2_q;
  logic [EIW-1:0] eidx_q;
  logic [15:0]    efr_q;
  logic [3:0]     eip3_q;
  logic [16:0]    ea_q;
  logic [16:0]    eb_q;
  logic [15:0]    efr3_q;
  logic [3:0]     eip4_q;
  logic [16:0]    ev_q;
  logic [16:0]    ex_q [5:7];
  logic [EPW-1:0] ep_d;
  logic [32:0]    edel;

  logic [33:0]    cv_q [6];
  logic [33:0]    cr_q [6];
  logic [33:0]    sdel;

  // select, scale, round
  logic                fv_q;
  logic [16:0]         f_q;
  logic [16:0]         f_d;
  logic                low7;
  logic                mv_q;
  logic signed [34:0]  prod_q;
  logic signed [34:0]  prod_d;
  logic signed [16:0]  dif;
  logic signed [17:0]  fs;
  logic signed [35:0]  rnd;
  logic signed [20:0]  res;
  logic signed [15:0]  sat_d;
  logic                done_q;
  logic signed [15:0]  value_q;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = eci_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q     <= 5'd0;
      start_val_q <= 16'sd0;
      end_val_q   <= 16'sd0;
      frames_q    <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_reg)
        eci_pkg::REG_CURVE:  curve_q     <= pwdata[4:0];
        eci_pkg::REG_START:  start_val_q <= pwdata[15:0];
        eci_pkg::REG_END:    end_val_q   <= pwdata[15:0];
        eci_pkg::REG_FRAMES: frames_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      eci_pkg::REG_CURVE:  prdata = {27'd0, curve_q};
      eci_pkg::REG_START:  prdata = {16'd0, start_val_q};
      eci_pkg::REG_END:    prdata = {16'd0, end_val_q};
      eci_pkg::REG_FRAMES: prdata = {16'd0, frames_q};
      default:             prdata = 32'd0;
    endcase
  end

  assign cur    = eci_pkg::decode_curve(curve_q);
  assign frames = (frames_q == 16'd0) ? 16'd1 : frames_q;
  assign busy   = 1'b0;

  // clamp the frame position
  assign cnt_clamp = (frame_count_i > frames) ? frames : frame_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    drem_q[0] <= 17'(cnt_clamp);
    dquo_q[0] <= 17'd0;
  end

  // restoring divider, four quotient bits a stage, msb first
  for (genvar k = 1; k < 6; k++) begin : g_div
    logic [16:0] rem_c;
    logic [16:0] quo_c;
    always_comb begin
      rem_c = drem_q[k-1];
      quo_c = dquo_q[k-1];
      for (int j = 0; j < 4; j++) begin
        if (4 * (k - 1) + j <= 16) begin
          if (4 * (k - 1) + j > 0) begin
            rem_c = {rem_c[15:0], 1'b0};
          end
          if (rem_c >= 17'(frames)) begin
            rem_c = rem_c - 17'(frames);
            quo_c[16 - (4 * (k - 1) + j)] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= dv_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      drem_q[k] <= rem_c;
      dquo_q[k] <= quo_c;
    end
  end

  // curve arguments: xa for power and circle, xb for sine and exponent
  assign t_in   = dquo_q[5];
  assign u_in   = eci_pkg::ONE_Q16 - t_in;
  assign low_in = t_in < eci_pkg::HALF_Q16;
  assign t2w    = {t_in, 1'b0};
  assign t2     = t2w[16:0];
  assign u2     = {u_in[15:0], 1'b0};

  always_comb begin
    case (cur.mode)
      eci_pkg::MODE_IN: begin
        xa_d = t_in;
        xb_d = u_in;
      end
      eci_pkg::MODE_OUT: begin
        xa_d = u_in;
        xb_d = t_in;
      end
      default: begin
        xa_d = low_in ? t2 : u2;
        xb_d = low_in ? 17'(18'(eci_pkg::ONE_Q16) - t2w)
                      : 17'(t2w - 18'(eci_pkg::ONE_Q16));
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else begin
      pv_q[0] <= dv_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    tp_q[0] <= t_in;
    xa_q[0] <= xa_d;
    xb_q    <= xb_d;
  end

  // control line through the curve stages
  for (genvar s = 1; s < 8; s++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[s] <= 1'b0;
      end else begin
        pv_q[s] <= pv_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      tp_q[s] <= tp_q[s-1];
    end
  end

  for (genvar s = 1; s < 4; s++) begin : g_xa
    always_ff @(posedge clk_i) begin
      xa_q[s] <= xa_q[s-1];
    end
  end

  // power by repeated products; the first square also feeds the circle
  always_ff @(posedge clk_i) begin
    pw_q[1] <= eci_pkg::mulq(xa_q[0], xa_q[0]);
  end

  for (genvar s = 2; s < 8; s++) begin : g_pow
    if (s <= 4) begin : g_mul
      always_ff @(posedge clk_i) begin
        if (cur.order > 3'(s)) begin
          pw_q[s] <= eci_pkg::mulq(pw_q[s-1], xa_q[s-1]);
        end else begin
          pw_q[s] <= pw_q[s-1];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        pw_q[s] <= pw_q[s-1];
      end
    end
  end

  // sine: table position, table read, interpolation
  assign sp_d = SPW'(xb_q) * SPW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    sidx_q <= sp_d[SPW-1:16];
    sfr_q  <= sp_d[15:0];
    ssat_q <= sp_d[SPW-1:16] >= SINE_LAST;
  end

  always_ff @(posedge clk_i) begin
    sa_q   <= SINE_ROM[ssat_q ? SINE_LAST : sidx_q];
    sb_q   <= SINE_ROM[ssat_q ? SINE_LAST : sidx_q + SIW'(1)];
    sfr2_q <= ssat_q ? 16'd0 : sfr_q;
  end

  assign sdel = 34'(sb_q - sa_q) * 34'(sfr2_q);

  always_ff @(posedge clk_i) begin
    sv_q[3] <= sa_q + sdel[32:16];
  end

  for (genvar s = 4; s < 8; s++) begin : g_sine
    always_ff @(posedge clk_i) begin
      sv_q[s] <= sv_q[s-1];
    end
  end

  // exponent: scale by ten, table position, read, interpolate, shift
  always_ff @(posedge clk_i) begin
    ee_q <= 20'(xb_q) * 20'd10;
  end

  assign ep_d = EPW'(ee_q[15:0]) * EPW'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    eip2_q <= ee_q[19:16];
    eidx_q <= ep_d[EPW-1:16];
    efr_q  <= ep_d[15:0];
  end

  always_ff @(posedge clk_i) begin
    ea_q   <= EXP_ROM[eidx_q];
    eb_q   <= EXP_ROM[eidx_q + EIW'(1)];
    efr3_q <= efr_q;
    eip3_q <= eip2_q;
  end

  assign edel = 33'(ea_q - eb_q) * 33'(efr3_q);

  always_ff @(posedge clk_i) begin
    ev_q   <= ea_q - edel[32:16];
    eip4_q <= eip3_q;
  end

  always_ff @(posedge clk_i) begin
    ex_q[5] <= ev_q >> eip4_q;
  end

  for (genvar s = 6; s < 8; s++) begin : g_expo
    always_ff @(posedge clk_i) begin
      ex_q[s] <= ex_q[s-1];
    end
  end

  // circle: bitwise square root, three result bits a stage
  for (genvar g = 0; g < 6; g++) begin : g_sqrt
    logic [33:0] v_in;
    logic [33:0] r_in;
    logic [33:0] v_c;
    logic [33:0] r_c;
    logic [33:0] trial;
    if (g == 0) begin : g_first
      assign v_in = {1'b0, 17'(eci_pkg::ONE_Q16 - pw_q[1]), 16'd0};
      assign r_in = 34'd0;
    end else begin : g_next
      assign v_in = cv_q[g-1];
      assign r_in = cr_q[g-1];
    end
    always_comb begin
      v_c   = v_in;
      r_c   = r_in;
      trial = 34'd0;
      for (int j = 0; j < 3; j++) begin
        if (3 * g + j <= 16) begin
          trial = r_c + (34'd1 << (32 - 2 * (3 * g + j)));
          if (v_c >= trial) begin
            v_c = v_c - trial;
            r_c = (r_c >> 1) + (34'd1 << (32 - 2 * (3 * g + j)));
          end else begin
            r_c = r_c >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      cv_q[g] <= v_c;
      cr_q[g] <= r_c;
    end
  end

  // curve value by family and form
  assign low7 = tp_q[7] < eci_pkg::HALF_Q16;

  always_comb begin
    logic [17:0] sum18;
    logic [16:0] c;
    sum18 = 18'd0;
    c     = cr_q[5][16:0];
    case (cur.fam)
      eci_pkg::FAM_POLY: begin
        case (cur.mode)
          eci_pkg::MODE_IN:  f_d = pw_q[7];
          eci_pkg::MODE_OUT: f_d = eci_pkg::ONE_Q16 - pw_q[7];
          default: f_d = low7 ? (pw_q[7] >> 1) : eci_pkg::ONE_Q16 - (pw_q[7] >> 1);
        endcase
      end
      eci_pkg::FAM_SINE: begin
        case (cur.mode)
          eci_pkg::MODE_IN:  f_d = eci_pkg::ONE_Q16 - sv_q[7];
          eci_pkg::MODE_OUT: f_d = sv_q[7];
          default: begin
            sum18 = low7 ? 18'(eci_pkg::ONE_Q16 - sv_q[7])
                         : 18'(eci_pkg::ONE_Q16) + 18'(sv_q[7]);
            f_d   = sum18[17:1];
          end
        endcase
      end
      eci_pkg::FAM_EXPO: begin
        case (cur.mode)
          eci_pkg::MODE_IN:  f_d = (tp_q[7] == 17'd0) ? 17'd0 : ex_q[7];
          eci_pkg::MODE_OUT: f_d = (tp_q[7] == eci_pkg::ONE_Q16) ? eci_pkg::ONE_Q16
                                   : eci_pkg::ONE_Q16 - ex_q[7];
          default: begin
            sum18 = 18'h20000 - 18'(ex_q[7]);
            if (low7) begin
              f_d = (tp_q[7] == 17'd0) ? 17'd0 : (ex_q[7] >> 1);
            end else if (tp_q[7] == eci_pkg::ONE_Q16) begin
              f_d = eci_pkg::ONE_Q16;
            end else begin
              f_d = sum18[17:1];
            end
          end
        endcase
      end
      eci_pkg::FAM_CIRC: begin
        case (cur.mode)
          eci_pkg::MODE_IN:  f_d = eci_pkg::ONE_Q16 - c;
          eci_pkg::MODE_OUT: f_d = c;
          default: begin
            sum18 = low7 ? 18'(eci_pkg::ONE_Q16 - c)
                         : 18'(eci_pkg::ONE_Q16) + 18'(c);
            f_d   = sum18[17:1];
          end
        endcase
      end
      default: f_d = tp_q[7];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= pv_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
  end

  // scale the span by the curve value
  assign dif    = 17'(end_val_q) - 17'(start_val_q);
  assign fs     = {1'b0, f_q};
  assign prod_d = 35'(dif) * 35'(fs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // round half up, add the start value and saturate
  assign rnd = 36'(prod_q) + 36'sd32768;
  assign res = 21'(start_val_q) + 21'($signed(rnd[35:16]));

  always_comb begin
    if (res > 21'sd32767) begin
      sat_d = 16'sh7fff;
    end else if (res < -21'sd32768) begin
      sat_d = -16'sh8000;
    end else begin
      sat_d = res[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= sat_d;
  end

  assign done_o        = done_q;
  assign eased_value_o = value_q;

endmodule

`default_nettype wire
